/* rtl/midi_to_cv_gate_port_core_assert.svh */
// Assertion macros used by the checker file of the port core.
`ifndef MIDI_TO_CV_GATE_PORT_CORE_ASSERT_SVH
`define MIDI_TO_CV_GATE_PORT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MTCV_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("port core check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define MTCV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("port core check failed");

`endif

/* rtl/mtcv_pkg.sv */
package mtcv_pkg;

   // Message kinds
   localparam logic [3:0] KIND_NOTE_ON       = 4'd0;
   localparam logic [3:0] KIND_POLY_PRESSURE = 4'd1;
   localparam logic [3:0] KIND_CC            = 4'd2;
   localparam logic [3:0] KIND_CHAN_PRESSURE = 4'd3;
   localparam logic [3:0] KIND_BEND          = 4'd4;
   localparam logic [3:0] KIND_STOP          = 4'd5;
   localparam logic [3:0] KIND_START         = 4'd6;
   localparam logic [3:0] KIND_CONTINUE      = 4'd7;
   localparam logic [3:0] KIND_CLOCK         = 4'd8;

   // Request types
   localparam logic REQ_MIDI     = 1'b0;
   localparam logic REQ_END_NOTE = 1'b1;

   // Clock modes
   localparam logic [2:0] MODE_SYNC     = 3'd0;
   localparam logic [2:0] MODE_GATE     = 3'd1;
   localparam logic [2:0] MODE_TRIG_STA = 3'd2;
   localparam logic [2:0] MODE_TRIG_CON = 3'd3;
   localparam logic [2:0] MODE_TRIG_STP = 3'd4;

   // Status codes
   localparam logic [1:0] ST_ACTIVE     = 2'd0;
   localparam logic [1:0] ST_ACTIVE_CC  = 2'd1;
   localparam logic [1:0] ST_ACTIVE_CLK = 2'd2;
   localparam logic [1:0] ST_INACTIVE   = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_TRANSPORT_MODE = 2'd0;
   localparam logic [1:0] CSR_PULSE_RATE     = 2'd1;
   localparam logic [1:0] CSR_VELOCITY       = 2'd2;
   localparam logic [1:0] CSR_PORT_ID        = 2'd3;

   localparam int CSR_DATA_W = 8;

   localparam logic [7:0] NOTE_NONE       = 8'd255;
   localparam logic [7:0] NOTE_MIDDLE     = 8'd60;
   localparam logic [7:0] RATE_RESET      = 8'd24;
   localparam logic [7:0] TICK_GATE_LOW   = 8'd5;
   localparam logic [7:0] TICK_GATE_HIGH  = 8'd1;
   localparam logic [15:0] CC_GATE_THRESH = 16'd64;

   typedef struct packed {
      logic [2:0] transport_mode;
      logic [7:0] ticks_per_pulse;
      logic       velocity_output;
      logic [2:0] port_id;
   } cfg_type;

   typedef struct packed {
      logic [7:0] held_note;
      logic [7:0] tick_count;
      logic       gate_state;
   } state_type;

   typedef struct packed {
      logic       req_type;
      logic [3:0] msg_kind;
      logic [7:0] data_first;
      logic [7:0] data_second;
   } req_item_type;

   typedef struct packed {
      logic              dac_write;
      logic signed [15:0] dac_level;
      logic              gate_write;
      logic              gate_level;
      logic              status_valid;
      logic [1:0]        status_code;
      logic [2:0]        status_port;
      logic [7:0]        status_note;
   } rsp_item_type;

endpackage

/* rtl/mtcv_req_if.sv */
interface mtcv_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [3:0] msg_kind;
   logic [7:0] data_first;
   logic [7:0] data_second;

   modport source (output valid, req_type, msg_kind, data_first, data_second, input ready);
   modport sink (input valid, req_type, msg_kind, data_first, data_second, output ready);
endinterface

/* rtl/mtcv_rsp_if.sv */
interface mtcv_rsp_if;
   logic              valid;
   logic              ready;
   logic              dac_write;
   logic signed [15:0] dac_level;
   logic              gate_write;
   logic              gate_level;
   logic              status_valid;
   logic [1:0]        status_code;
   logic [2:0]        status_port;
   logic [7:0]        status_note;

   modport source (output valid, dac_write, dac_level, gate_write, gate_level,
                   status_valid, status_code, status_port, status_note, input ready);
   modport sink (input valid, dac_write, dac_level, gate_write, gate_level,
                 status_valid, status_code, status_port, status_note, output ready);
endinterface

/* rtl/midi_to_cv_gate_port_core.sv */
// Path: a transaction accepted into the input register moves on to the result register,
// where it is offered (input register, then result register); it is held back while
// the result side stalls. Throughput: one transaction per cycle unless the result side
// stalls; the decode is a single short pass.
// Reset (synchronous, active high): no note held, tick count and gate low,
// registers back to sync mode, rate 24, pitch output, port 0; both stages empty.
module midi_to_cv_gate_port_core (
   input  logic                                  clock,
   input  logic                                  reset,
   mtcv_req_if.sink                              req_chan,
   mtcv_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [mtcv_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import mtcv_pkg::*;

   cfg_type      cfg_ff;
   state_type    state_ff;
   state_type    state_in;
   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;
   logic         rsp_free;
   logic         s1_advance;
   logic         req_accept;

   // Handshake: stage one moves on when the result register is free
   assign rsp_free      = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance    = s1_valid_ff && rsp_free;
   assign req_chan.ready = !s1_valid_ff || rsp_free;
   assign req_accept    = req_chan.valid && req_chan.ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transport_mode  <= MODE_SYNC;
         cfg_ff.ticks_per_pulse <= RATE_RESET;
         cfg_ff.velocity_output <= 1'b0;
         cfg_ff.port_id         <= 3'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRANSPORT_MODE: cfg_ff.transport_mode  <= csr_wdata[2:0];
            CSR_PULSE_RATE:     cfg_ff.ticks_per_pulse <= csr_wdata[7:0];
            CSR_VELOCITY:       cfg_ff.velocity_output <= csr_wdata[0];
            CSR_PORT_ID:        cfg_ff.port_id         <= csr_wdata[2:0];
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.req_type    <= req_chan.req_type;
         s1_item_ff.msg_kind    <= req_chan.msg_kind;
         s1_item_ff.data_first  <= req_chan.data_first;
         s1_item_ff.data_second <= req_chan.data_second;
      end
   end

   mtcv_port_calc u_calc (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (s1_item_ff),
      .state_next (state_in),
      .result     (rsp_item_in)
   );

   // Port state advances with each transaction leaving stage one
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.held_note  <= NOTE_NONE;
         state_ff.tick_count <= 8'd0;
         state_ff.gate_state <= 1'b0;
      end else if (s1_advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.dac_write    = rsp_item_ff.dac_write;
   assign rsp_chan.dac_level    = rsp_item_ff.dac_level;
   assign rsp_chan.gate_write   = rsp_item_ff.gate_write;
   assign rsp_chan.gate_level   = rsp_item_ff.gate_level;
   assign rsp_chan.status_valid = rsp_item_ff.status_valid;
   assign rsp_chan.status_code  = rsp_item_ff.status_code;
   assign rsp_chan.status_port  = rsp_item_ff.status_port;
   assign rsp_chan.status_note  = rsp_item_ff.status_note;

endmodule

/* rtl/mtcv_port_calc.sv */
module mtcv_port_calc (
   input  mtcv_pkg::cfg_type      cfg,
   input  mtcv_pkg::state_type    state,
   input  mtcv_pkg::req_item_type item,
   output mtcv_pkg::state_type    state_next,
   output mtcv_pkg::rsp_item_type result
);
   import mtcv_pkg::*;

   // Pitch level: signed semitone offset from the middle note times 544
   function automatic logic [15:0] pitch_level(input logic [7:0] note);
      logic [7:0]  diff;
      logic [15:0] ext;
      diff = note - NOTE_MIDDLE;
      ext  = {{8{diff[7]}}, diff};
      return (ext << 9) + (ext << 5);
   endfunction

   logic               dac_en;
   logic               gate_en;
   logic               stat_en;
   logic [15:0]        level;
   logic               gate_val;
   logic [1:0]         code;
   logic [7:0]         tick_inc;
   logic [15:0]        cc_word;
   logic signed [24:0] bend_ext;
   logic signed [24:0] bend_prod;
   logic signed [24:0] bend_bias;
   logic signed [24:0] bend_quot;
   logic [15:0]        bend_off4;

   // Bend offset: value * 272 / 8192, truncated toward zero, then times 4
   always_comb begin
      bend_ext  = {{9{item.data_first[7]}}, item.data_first, item.data_second};
      bend_prod = (bend_ext <<< 8) + (bend_ext <<< 4);
      bend_bias = bend_prod[24] ? 25'sd8191 : 25'sd0;
      bend_quot = (bend_prod + bend_bias) >>> 13;
      bend_off4 = {bend_quot[13:0], 2'b00};
   end

   assign tick_inc = state.tick_count + 8'd1;
   assign cc_word  = {1'b0, item.data_first, 7'b0} + {8'b0, item.data_second};

   // Decode one item against the current state
   always_comb begin
      dac_en     = 1'b1;
      gate_en    = 1'b1;
      stat_en    = 1'b1;
      level      = 16'd0;
      gate_val   = 1'b1;
      code       = ST_ACTIVE;
      state_next = state;

      if (item.req_type == REQ_END_NOTE) begin
         state_next.held_note = NOTE_NONE;
         dac_en               = 1'b0;
         gate_val             = 1'b0;
         code                 = ST_INACTIVE;
      end else begin
         unique case (item.msg_kind)
            KIND_NOTE_ON: begin
               state_next.held_note = item.data_first;
               if (cfg.velocity_output) begin
                  level = {5'b0, item.data_second, 3'b0};
               end else begin
                  level = pitch_level(item.data_first);
               end
            end
            KIND_POLY_PRESSURE: begin
               level   = {5'b0, item.data_second, 3'b0};
               gate_en = 1'b0;
            end
            KIND_CC: begin
               level    = {cc_word[14:0], 1'b0};
               gate_val = (cc_word >= CC_GATE_THRESH);
               code     = ST_ACTIVE_CC;
            end
            KIND_CHAN_PRESSURE: begin
               level   = {5'b0, item.data_first, 3'b0};
               gate_en = 1'b0;
            end
            KIND_BEND: begin
               gate_en = 1'b0;
               if (state.held_note != NOTE_NONE) begin
                  level = pitch_level(state.held_note) + bend_off4;
               end else begin
                  level = bend_off4;
               end
            end
            KIND_STOP: begin
               dac_en = 1'b0;
               if (cfg.transport_mode == MODE_TRIG_STP) begin
                  code = ST_ACTIVE_CLK;
               end else begin
                  code     = ST_INACTIVE;
                  gate_val = 1'b0;
               end
            end
            KIND_START, KIND_CONTINUE: begin
               dac_en = 1'b0;
               priority if (item.msg_kind == KIND_START &&
                            cfg.transport_mode == MODE_TRIG_STA) begin
                  code = ST_ACTIVE_CLK;
               end else if (item.msg_kind == KIND_START &&
                            cfg.transport_mode > MODE_GATE) begin
                  code     = ST_INACTIVE;
                  gate_val = 1'b0;
               end else if (cfg.transport_mode == MODE_SYNC) begin
                  state_next.tick_count = 8'd0;
                  code                  = ST_INACTIVE;
                  gate_val              = 1'b0;
               end else if (cfg.transport_mode == MODE_GATE ||
                            cfg.transport_mode == MODE_TRIG_CON) begin
                  code = ST_ACTIVE_CLK;
               end else begin
                  code     = ST_INACTIVE;
                  gate_val = 1'b0;
               end
            end
            KIND_CLOCK: begin
               dac_en = 1'b0;
               if (cfg.transport_mode != MODE_SYNC) begin
                  gate_en = 1'b0;
                  stat_en = 1'b0;
               end else begin
                  code                  = ST_ACTIVE_CLK;
                  state_next.tick_count = tick_inc;
                  priority if (tick_inc >= cfg.ticks_per_pulse) begin
                     state_next.tick_count = 8'd0;
                  end else if (tick_inc == TICK_GATE_LOW) begin
                     gate_val = 1'b0;
                     code     = ST_INACTIVE;
                  end else if (tick_inc == TICK_GATE_HIGH) begin
                     gate_val = 1'b1;
                  end else begin
                     gate_en = 1'b0;
                     stat_en = 1'b0;
                  end
               end
            end
            default: begin
               // Unhandled kinds: DAC to zero, gate high, plain active report
               level = 16'd0;
            end
         endcase
      end

      if (gate_en) begin
         state_next.gate_state = gate_val;
      end
   end

   // Assemble the result, zeroing the DAC and report fields that are not written
   always_comb begin
      result.dac_write    = dac_en;
      result.dac_level    = dac_en ? level : 16'd0;
      result.gate_write   = gate_en;
      result.gate_level   = state_next.gate_state;
      result.status_valid = stat_en;
      result.status_code  = stat_en ? code : ST_ACTIVE;
      result.status_port  = stat_en ? cfg.port_id : 3'd0;
      result.status_note  = stat_en ? state_next.held_note : 8'd0;
   end

endmodule

/* rtl/mtcv_checker.sv */
`include "midi_to_cv_gate_port_core_assert.svh"

module mtcv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        dac_write,
   input logic [15:0] dac_level,
   input logic        gate_write,
   input logic        gate_level,
   input logic        status_valid,
   input logic [1:0]  status_code,
   input logic [2:0]  status_port,
   input logic [7:0]  status_note
);
   import mtcv_pkg::*;

   logic report_empty;

   assign report_empty = status_code == ST_ACTIVE && status_port == 3'd0 &&
                         status_note == 8'd0;

   // Unwritten DAC level reads as zero
   `MTCV_ASSERT_IMPL(a_dac_zero, rsp_valid && !dac_write, dac_level == 16'd0)

   // No report means empty report fields
   `MTCV_ASSERT_IMPL(a_status_zero, rsp_valid && !status_valid, report_empty)

   // An inactive report always comes with a low gate write
   `MTCV_ASSERT_IMPL(a_inactive_gate, rsp_valid && status_valid && status_code == ST_INACTIVE, gate_write && !gate_level)

   // A clock-driven activation always raises the gate
   `MTCV_ASSERT_IMPL(a_clock_gate, rsp_valid && status_valid && status_code == ST_ACTIVE_CLK, gate_write && gate_level)

   // A stalled transaction stays put
   `MTCV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(dac_level) && $stable(status_note))

endmodule

bind midi_to_cv_gate_port_core mtcv_checker u_mtcv_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .dac_write    (rsp_chan.dac_write),
   .dac_level    (rsp_chan.dac_level),
   .gate_write   (rsp_chan.gate_write),
   .gate_level   (rsp_chan.gate_level),
   .status_valid (rsp_chan.status_valid),
   .status_code  (rsp_chan.status_code),
   .status_port  (rsp_chan.status_port),
   .status_note  (rsp_chan.status_note)
);
